// ----- hdl/utf8_byte_decoder_core_defines.svh -----
// assertion macros for the utf8 byte decoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef UTF8_BYTE_DECODER_CORE_DEFINES_SVH
`define UTF8_BYTE_DECODER_CORE_DEFINES_SVH

// property checked on every rising edge, idle while reset is held
`define UBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same check, no reset qualification
`define UBD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/utf8d_pkg.sv -----
// shared types and constants for the utf8 byte decoder
// no dependencies
package utf8d_pkg;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int PEND_W   = 2;
	localparam int DATA_W   = 24;
	localparam int USER_W   = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W    = $clog2(FIFO_DEPTH);
	localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);

	localparam logic [CP_W-1:0] REPL_RESET = CP_W'(32);

	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
	localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
	localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_replacement;
		logic            last_of_run;
		logic            string_done;
	} result_t;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic [CP_W-1:0]   acc;
	} dec_state_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

// ----- hdl/utf8d_decode.sv -----
// per-byte decode logic: next state and up to two results
// depends on utf8d_pkg
module utf8d_decode (
	input  logic [utf8d_pkg::BYTE_W-1:0] byte_value,
	input  logic                         text_end,
	input  utf8d_pkg::dec_state_t        st,
	input  logic [utf8d_pkg::CP_W-1:0]   repl,
	output utf8d_pkg::dec_state_t        nxt,
	output utf8d_pkg::push_t             res
);

	logic                       pre_v;
	logic                       main_v;
	logic                       main_rep;
	logic [utf8d_pkg::CP_W-1:0] main_cp;
	logic                       end_v;
	utf8d_pkg::result_t         repl_r;
	utf8d_pkg::result_t         main_r;

	always_comb begin
		nxt      = st;
		pre_v    = 1'b0;
		main_v   = 1'b0;
		main_rep = 1'b0;
		main_cp  = utf8d_pkg::CP_W'(byte_value);
		if (byte_value <= utf8d_pkg::ASCII_MAX) begin
			pre_v       = (st.pending != '0);
			nxt.pending = '0;
			main_v      = 1'b1;
		end else if (byte_value <= utf8d_pkg::CONT_MAX) begin
			if (st.pending != '0) begin
				nxt.acc     = {st.acc[utf8d_pkg::CP_W-7:0], byte_value[5:0]};
				nxt.pending = st.pending - utf8d_pkg::PEND_W'(1);
				main_v      = (st.pending == utf8d_pkg::PEND_W'(1));
				main_cp     = nxt.acc;
			end else begin
				main_v   = 1'b1;
				main_rep = 1'b1;
				main_cp  = repl;
			end
		end else if (byte_value <= utf8d_pkg::LEAD2_MAX) begin
			nxt.pending = utf8d_pkg::PEND_W'(1);
			nxt.acc     = utf8d_pkg::CP_W'(byte_value[4:0]);
		end else if (byte_value <= utf8d_pkg::LEAD3_MAX) begin
			nxt.pending = utf8d_pkg::PEND_W'(2);
			nxt.acc     = utf8d_pkg::CP_W'(byte_value[3:0]);
		end else if (byte_value <= utf8d_pkg::LEAD4_MAX) begin
			nxt.pending = utf8d_pkg::PEND_W'(3);
			nxt.acc     = utf8d_pkg::CP_W'(byte_value[2:0]);
		end else begin
			main_v      = 1'b1;
			main_rep    = 1'b1;
			main_cp     = repl;
			nxt.pending = '0;
		end

		// truncated sequence at string end
		end_v = text_end && (nxt.pending != '0);
		if (text_end) begin
			nxt.pending = '0;
			nxt.acc     = '0;
		end

		repl_r = '{code_point: repl, is_replacement: 1'b1,
			last_of_run: 1'b0, string_done: 1'b0};
		main_r = '{code_point: main_cp, is_replacement: main_rep,
			last_of_run: 1'b0, string_done: 1'b0};

		res.v0 = pre_v || main_v || end_v;
		res.v1 = (pre_v && main_v) || (main_v && end_v);
		res.r0 = (pre_v || !main_v) ? repl_r : main_r;
		res.r1 = pre_v ? main_r : repl_r;

		res.r0.last_of_run = !res.v1;
		res.r0.string_done = !res.v1 && text_end;
		res.r1.last_of_run = 1'b1;
		res.r1.string_done = text_end;
	end

endmodule

// ----- hdl/utf8d_res_fifo.sv -----
// result queue: takes up to two results a cycle, gives one a cycle while popped
// depends on utf8d_pkg
module utf8d_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8d_pkg::push_t   push,
	input  logic               pop,
	output logic               room,
	output logic               head_v,
	output utf8d_pkg::result_t head
);

	utf8d_pkg::result_t              mem [utf8d_pkg::FIFO_DEPTH];
	logic [utf8d_pkg::PTR_W-1:0]     wptr_q;
	logic [utf8d_pkg::PTR_W-1:0]     rptr_q;
	logic [utf8d_pkg::CNT_W-1:0]     count_q;
	logic [utf8d_pkg::PTR_W-1:0]     wptr_p1;
	logic [utf8d_pkg::CNT_W-1:0]     push_n;
	logic                            do_pop;

	assign wptr_p1 = wptr_q + utf8d_pkg::PTR_W'(1);
	assign push_n  = utf8d_pkg::CNT_W'(push.v0) + utf8d_pkg::CNT_W'(push.v1);
	assign head_v  = (count_q != '0);
	assign do_pop  = head_v && pop;
	assign head    = mem[rptr_q];
	// room for a full pair of results
	assign room    = (count_q <= utf8d_pkg::CNT_W'(utf8d_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem[wptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + utf8d_pkg::PTR_W'(push_n);
			if (do_pop) begin
				rptr_q <= rptr_q + utf8d_pkg::PTR_W'(1);
			end
			count_q <= count_q + push_n - utf8d_pkg::CNT_W'(do_pop);
		end
	end

endmodule

// ----- hdl/utf8_byte_decoder_core.sv -----
// utf8 byte decoder top level: input register, decode, result queue
// depends on utf8d_pkg, utf8d_decode, utf8d_res_fifo
// path: the input register, then decode, then the result queue, whose head is the result beat
// throughput: one byte per cycle; a byte giving two results holds two output beats
// input stalls only when the result queue (four entries) lacks room for a pair
// reset: async active low, clears decode state and queue, sets replacement code to space
module utf8_byte_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [utf8d_pkg::BYTE_W-1:0]      s_tdata,  // byte_value
	input  logic                              s_tlast,  // text_end
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [utf8d_pkg::DATA_W-1:0]      m_tdata,  // code_point, zero pad
	output logic [utf8d_pkg::USER_W-1:0]      m_tuser,  // is_replacement, string_done
	output logic                              m_tlast,  // last_of_run
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [utf8d_pkg::CP_W-1:0]        cfg_data  // replacement_code
);

	logic                         v_s1;
	logic [utf8d_pkg::BYTE_W-1:0] byte_s1;
	logic                         end_s1;
	utf8d_pkg::dec_state_t        st_q;
	utf8d_pkg::dec_state_t        st_nxt;
	logic [utf8d_pkg::CP_W-1:0]   repl_q;
	utf8d_pkg::push_t             dec_res;
	utf8d_pkg::push_t             push;
	logic                         room;
	logic                         adv;
	utf8d_pkg::result_t           head;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && room;
	assign s_tready  = !v_s1 || room;

	utf8d_decode u_decode (
		.byte_value (byte_s1),
		.text_end   (end_s1),
		.st         (st_q),
		.repl       (repl_q),
		.nxt        (st_nxt),
		.res        (dec_res)
	);

	always_comb begin
		push    = dec_res;
		push.v0 = dec_res.v0 && adv;
		push.v1 = dec_res.v1 && adv;
	end

	utf8d_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_tready),
		.room   (room),
		.head_v (m_tvalid),
		.head   (head)
	);

	assign m_tdata = utf8d_pkg::DATA_W'(head.code_point);
	assign m_tuser = {head.string_done, head.is_replacement};
	assign m_tlast = head.last_of_run;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			st_q   <= '0;
			repl_q <= utf8d_pkg::REPL_RESET;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				st_q <= st_nxt;
			end
			if (cfg_valid && cfg_ready) begin
				repl_q <= cfg_data;
			end
		end
	end

endmodule

// ----- hdl/utf8d_checker.sv -----
// port-level checks for the utf8 byte decoder, bound to the top level
// depends on utf8d_pkg and utf8_byte_decoder_core_defines.svh
`include "utf8_byte_decoder_core_defines.svh"

module utf8d_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [utf8d_pkg::DATA_W-1:0] m_tdata,
	input logic [utf8d_pkg::USER_W-1:0] m_tuser,
	input logic                         m_tlast
);

	// stalled result beat holds
	`UBD_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")
	// string end only on the last beat of a byte
	`UBD_ASSERT(a_done_last, m_tvalid && m_tuser[1] |-> m_tlast, "string_done without last_of_run")
	// second result of a byte is queued together with the first
	`UBD_ASSERT(a_pair, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "second result of a byte missing")
	// input back-pressure only comes from pending results
	`UBD_ASSERT(a_stall_src, !s_tready |-> m_tvalid, "input stalled with no result waiting")

endmodule

bind utf8_byte_decoder_core utf8d_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- tb/sv/utf8_byte_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for utf8_byte_decoder_core: directed and random byte streams,
// a predictor of the decoded code points and a result checker
// depends on utf8d_pkg and utf8_byte_decoder_core
module utf8_byte_decoder_core_tb;
	import utf8d_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE_WAIT  = 6;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_OCTETS = 276;

	class codepoint_board;
		result_t          due_codes[$];
		logic [PEND_W-1:0] pending;
		logic [CP_W-1:0]   acc;
		logic [CP_W-1:0]   repl;
		int                errors;

		function new();
			pending = '0;
			acc     = '0;
			repl    = REPL_RESET;
			errors  = 0;
		endfunction

		function void set_repl(logic [CP_W-1:0] v);
			repl = v;
		endfunction

		function void take_octet(logic [BYTE_W-1:0] b, logic fin);
			result_t outs[2];
			int      n;
			n = 0;
			if (b <= ASCII_MAX) begin
				if (pending != 0) begin
					outs[n] = {repl, 3'b100};
					n++;
					pending = '0;
				end
				outs[n] = {13'd0, b, 3'b000};
				n++;
			end else if (b <= CONT_MAX) begin
				if (pending != 0) begin
					acc = {acc[CP_W-7:0], b[5:0]};
					pending = pending - 1'b1;
					if (pending == 0) begin
						outs[n] = {acc, 3'b000};
						n++;
					end
				end else begin
					outs[n] = {repl, 3'b100};
					n++;
				end
			end else if (b <= LEAD2_MAX) begin
				pending = 2'd1;
				acc = CP_W'(b[4:0]);
			end else if (b <= LEAD3_MAX) begin
				pending = 2'd2;
				acc = CP_W'(b[3:0]);
			end else if (b <= LEAD4_MAX) begin
				pending = 2'd3;
				acc = CP_W'(b[2:0]);
			end else begin
				outs[n] = {repl, 3'b100};
				n++;
				pending = '0;
			end
			if (fin) begin
				if (pending != 0) begin
					outs[n] = {repl, 3'b100};
					n++;
				end
				pending = '0;
				acc = '0;
			end
			if (n > 0) begin
				outs[n-1].last_of_run = 1'b1;
				outs[n-1].string_done = fin;
			end
			for (int i = 0; i < n; i++)
				due_codes = {due_codes, outs[i]};
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task match_code(logic [DATA_W-1:0] data, logic [USER_W-1:0] user, logic last);
			result_t want;
			if (due_codes.size() == 0) begin
				report($sformatf("unexpected result beat, code_point %h", data[CP_W-1:0]));
				return;
			end
			want = due_codes.pop_front();
			if (data[CP_W-1:0] !== want.code_point)
				report($sformatf("code_point %h, want %h", data[CP_W-1:0], want.code_point));
			if (user[0] !== want.is_replacement)
				report($sformatf("is_replacement %b, want %b", user[0], want.is_replacement));
			if (last !== want.last_of_run)
				report($sformatf("last_of_run %b, want %b", last, want.last_of_run));
			if (user[1] !== want.string_done)
				report($sformatf("string_done %b, want %b", user[1], want.string_done));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata = '0;  // byte_value
	logic                s_tlast = 1'b0;  // text_end
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;  // code_point, zero pad
	logic [USER_W-1:0]   m_tuser;  // is_replacement, string_done
	logic                m_tlast;  // last_of_run
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CP_W-1:0]     cfg_data = '0;  // replacement_code

	logic tx_idle_on = 1'b1;
	logic rx_idle_on = 1'b1;
	logic hold_rx = 1'b0;
	int   octets_sent = 0;
	int   quiet_cycles = 0;

	codepoint_board board = new();

	utf8_byte_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result side: check each beat, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_code(m_tdata, m_tuser, m_tlast);
		m_tready <= arst_n && !hold_rx && (!rx_idle_on || $urandom_range(99) >= 29);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
			$display("utf8_byte_decoder_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task send_octet(input logic [BYTE_W-1:0] b, input logic fin);
		while (tx_idle_on && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		board.take_octet(b, fin);
		octets_sent++;
	endtask

	task write_repl(input logic [CP_W-1:0] v);
		s_tvalid <= 1'b0;
		while (board.due_codes.size() != 0) @(posedge clk);
		// a lead byte gives no result, so let it settle
		repeat (SETTLE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_repl(v);
	endtask

	task send_directed();
		logic [8:0] plan [23];
		plan = '{9'h000, 9'h17F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
			9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0E2, 9'h041,
			9'h0E2, 9'h0C3, 9'h0A9, 9'h0E2, 9'h0F8, 9'h0F0, 9'h19F, 9'h1C3, 9'h0FF};
		foreach (plan[i])
			send_octet(plan[i][7:0], plan[i][8]);
	endtask

	// mostly well-formed characters, some cut short, some stray bytes
	task send_text(input int count);
		int              target;
		int              len;
		int              n;
		int              pick;
		logic [CP_W-1:0] cp;
		logic [BYTE_W-1:0] seq [4];
		target = octets_sent + count;
		while (octets_sent < target) begin
			pick = $urandom_range(99);
			len  = $urandom_range(1, 4);
			cp   = CP_W'($urandom);
			case (len)
				1: seq[0] = {1'b0, cp[6:0]};
				2: begin
					seq[0] = {3'b110, cp[10:6]};
					seq[1] = {2'b10, cp[5:0]};
				end
				3: begin
					seq[0] = {4'b1110, cp[15:12]};
					seq[1] = {2'b10, cp[11:6]};
					seq[2] = {2'b10, cp[5:0]};
				end
				default: begin
					seq[0] = {5'b11110, cp[20:18]};
					seq[1] = {2'b10, cp[17:12]};
					seq[2] = {2'b10, cp[11:6]};
					seq[3] = {2'b10, cp[5:0]};
				end
			endcase
			if (pick < 15) begin
				n = $urandom_range(1, len);
			end else if (pick < 30) begin
				n = 1;
				seq[0] = BYTE_W'($urandom);
			end else begin
				n = len;
			end
			for (int i = 0; i < n; i++)
				send_octet(seq[i], $urandom_range(9) == 0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();

		write_repl('0);
		tx_idle_on <= 1'b0;
		rx_idle_on <= 1'b0;
		send_text(PHASE_OCTETS);
		tx_idle_on <= 1'b1;
		rx_idle_on <= 1'b1;

		write_repl({CP_W{1'b1}});
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		send_text(PHASE_OCTETS);

		write_repl(CP_W'(21'h00FFFD));
		send_text(PHASE_OCTETS);

		write_repl(CP_W'($urandom));
		send_text(PHASE_OCTETS);

		write_repl(REPL_RESET);
		send_text(PHASE_OCTETS);

		s_tvalid <= 1'b0;
		while (board.due_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("utf8_byte_decoder_core test passed");
		else
			$display("utf8_byte_decoder_core test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/utf8d_pkg.sv
hdl/utf8d_decode.sv
hdl/utf8d_res_fifo.sv
hdl/utf8_byte_decoder_core.sv
hdl/utf8d_checker.sv
tb/sv/utf8_byte_decoder_core_tb.sv
